// ===== rtl/core/rrcm_pkg.sv =====
// Shared types, constants and the round-robin pick function of the crossbar matcher.
package rrcm_pkg;

    localparam int MAX_PORTS = 8;
    localparam int PTR_W     = 3;
    localparam int IDX_W     = 4;
    localparam int REQ_W     = MAX_PORTS * MAX_PORTS;

    localparam logic [IDX_W-1:0] UNMATCHED = IDX_W'(MAX_PORTS);

    typedef logic [MAX_PORTS-1:0] t_port_vec;
    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [IDX_W-1:0]     t_idx;

    // First candidate at or after ptr, else lowest candidate; UNMATCHED if none.
    function automatic t_idx rr_pick(input t_port_vec cand, input t_ptr ptr);
        t_idx hi;
        t_idx lo;
        hi = UNMATCHED;
        lo = UNMATCHED;
        for (int k = MAX_PORTS - 1; k >= 0; k--) begin
            if (cand[k] && (k >= int'(ptr))) begin
                hi = IDX_W'(k);
            end
            if (cand[k]) begin
                lo = IDX_W'(k);
            end
        end
        return (hi != UNMATCHED) ? hi : lo;
    endfunction

endpackage

// ===== rtl/core/rrcm_req_if.sv =====
// Request matrix channel of the crossbar matcher.
interface rrcm_req_if import rrcm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] request_matrix;

    modport source (output valid, output request_matrix, input ready);
    modport sink   (input valid, input request_matrix, output ready);
endinterface

// ===== rtl/core/rrcm_match_if.sv =====
// Match result channel of the crossbar matcher.
interface rrcm_match_if import rrcm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] match_in0;
    logic [IDX_W-1:0] match_in1;
    logic [IDX_W-1:0] match_in2;
    logic [IDX_W-1:0] match_in3;
    logic [IDX_W-1:0] match_in4;
    logic [IDX_W-1:0] match_in5;
    logic [IDX_W-1:0] match_in6;
    logic [IDX_W-1:0] match_in7;

    modport source (
        output valid, input ready,
        output match_in0, match_in1, match_in2, match_in3,
        output match_in4, match_in5, match_in6, match_in7
    );
    modport sink (
        input valid, output ready,
        input match_in0, match_in1, match_in2, match_in3,
        input match_in4, match_in5, match_in6, match_in7
    );
endinterface

// ===== rtl/core/round_robin_crossbar_matcher.sv =====
// Single-iteration round-robin (RRM) crossbar matcher, top level.
// One item per clock: a request matrix is captured in an input register, and the
// grant and accept arbiters (one 8-bit round-robin pick each, in series) run between
// that register and the match register, so an item's result is held in the match register
// after it leaves the input register, and a new item is taken every cycle while results are
// drained. The grant and accept pointers advance as each item moves into the match register.
// Ports at or above PORT_COUNT are ignored and report 8 (unmatched).
module round_robin_crossbar_matcher import rrcm_pkg::*; #(
    parameter int PORT_COUNT = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrcm_req_if.sink     i_req,
    rrcm_match_if.source o_match
);

    localparam t_idx PC_IDX = IDX_W'(PORT_COUNT);

    logic [REQ_W-1:0]                r_req;
    logic                            r_req_vld;
    logic [MAX_PORTS-1:0][IDX_W-1:0] r_match;
    logic                            r_out_vld;
    logic [MAX_PORTS-1:0][PTR_W-1:0] r_gptr;
    logic [MAX_PORTS-1:0][PTR_W-1:0] r_aptr;
    logic [MAX_PORTS-1:0][PTR_W-1:0] n_gptr;
    logic [MAX_PORTS-1:0][PTR_W-1:0] n_aptr;

    t_port_vec                       w_cand [MAX_PORTS];
    t_port_vec                       w_gnt_to [MAX_PORTS];
    t_port_vec                       w_col [MAX_PORTS];
    logic [MAX_PORTS-1:0][IDX_W-1:0] w_gsel;
    logic [MAX_PORTS-1:0][IDX_W-1:0] w_acc;
    logic                            w_adv;

    function automatic t_ptr next_ptr(input t_idx sel);
        t_idx n;
        n = sel + IDX_W'(1);
        if (n >= PC_IDX) begin
            n = '0;
        end
        return PTR_W'(n);
    endfunction

    assign w_adv       = r_req_vld && (!r_out_vld || o_match.ready);
    assign i_req.ready = !r_req_vld || w_adv;

    // grant phase
    always_comb begin
        n_gptr = r_gptr;
        for (int o = 0; o < MAX_PORTS; o++) begin
            for (int i = 0; i < MAX_PORTS; i++) begin
                w_cand[o][i] = (i < PORT_COUNT) && (o < PORT_COUNT) && r_req[i * MAX_PORTS + o];
            end
            w_gsel[o] = rr_pick(w_cand[o], r_gptr[o]);
            if (w_gsel[o] != UNMATCHED) begin
                n_gptr[o] = next_ptr(w_gsel[o]);
            end
        end
    end

    // accept phase
    always_comb begin
        n_aptr = r_aptr;
        for (int i = 0; i < MAX_PORTS; i++) begin
            for (int o = 0; o < MAX_PORTS; o++) begin
                w_gnt_to[i][o] = (w_gsel[o] == IDX_W'(i));
            end
            w_acc[i] = rr_pick(w_gnt_to[i], r_aptr[i]);
            if (w_acc[i] != UNMATCHED) begin
                n_aptr[i] = next_ptr(w_acc[i]);
            end
        end
        for (int o = 0; o < MAX_PORTS; o++) begin
            for (int i = 0; i < MAX_PORTS; i++) begin
                w_col[o][i] = (w_acc[i] == IDX_W'(o));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_gptr    <= '0;
            r_aptr    <= '0;
        end else begin
            if (i_req.ready) begin
                r_req_vld <= i_req.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_gptr    <= n_gptr;
                r_aptr    <= n_aptr;
            end else if (o_match.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.request_matrix;
        end
        if (w_adv) begin
            r_match <= w_acc;
        end
    end

    assign o_match.valid     = r_out_vld;
    assign o_match.match_in0 = r_match[0];
    assign o_match.match_in1 = r_match[1];
    assign o_match.match_in2 = r_match[2];
    assign o_match.match_in3 = r_match[3];
    assign o_match.match_in4 = r_match[4];
    assign o_match.match_in5 = r_match[5];
    assign o_match.match_in6 = r_match[6];
    assign o_match.match_in7 = r_match[7];

    generate
        for (genvar g = 0; g < MAX_PORTS; g++) begin : g_chk
            a_one_input_per_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_adv |-> $onehot0(w_col[g]))
                else $error("output matched to more than one input");
            a_gptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                int'(r_gptr[g]) < PORT_COUNT)
                else $error("grant pointer out of range");
        end
    endgenerate

    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_aptr) && $stable(r_gptr))
        else $error("pointers moved without an item");

    a_reset_ptr: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (r_gptr == '0) && (r_aptr == '0))
        else $error("pointers not cleared by reset");

endmodule

// ===== verif/round_robin_crossbar_matcher_test.sv =====
// Self-checking testbench for the single-iteration round-robin crossbar matcher.
module round_robin_crossbar_matcher_test import rrcm_pkg::*; ();

    localparam int N_PORTS = 8;

    typedef logic [MAX_PORTS-1:0][IDX_W-1:0] t_match_set;

    typedef enum int {
        IDLE_SENDER_HEAVY,
        IDLE_RECEIVER_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    logic clk = 1'b0;
    logic rst_n;

    rrcm_req_if   req_ch ();
    rrcm_match_if match_ch ();

    round_robin_crossbar_matcher #(
        .PORT_COUNT (N_PORTS)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_match (match_ch)
    );

    t_ptr out_grant_pos [MAX_PORTS];
    t_ptr in_accept_pos [MAX_PORTS];

    logic [REQ_W-1:0] request_backlog [$];
    t_match_set       pending_matches [$];

    int send_idle_pct;
    int recv_idle_pct;
    int err_count;
    int items_sent;
    int results_checked;
    int pairs_matched;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int rotate_pick(input t_port_vec cand, input t_ptr pos);
        int start;
        int k;
        start = (int'(pos) < N_PORTS) ? int'(pos) : 0;
        for (int off = 0; off < N_PORTS; off++) begin
            k = (start + off) % N_PORTS;
            if (cand[k]) begin
                return k;
            end
        end
        return MAX_PORTS;
    endfunction

    function automatic t_ptr step_past(input int sel);
        return (sel + 1 >= N_PORTS) ? t_ptr'(0) : t_ptr'(sel + 1);
    endfunction

    // Grant then accept for one time slot; advance both pointer sets.
    function automatic t_match_set schedule_slot(input logic [REQ_W-1:0] req);
        t_port_vec  granted_to [MAX_PORTS];
        t_port_vec  asking;
        t_match_set result;
        int         pick;
        for (int i = 0; i < MAX_PORTS; i++) begin
            granted_to[i] = '0;
            result[i]     = UNMATCHED;
        end
        for (int o = 0; o < N_PORTS; o++) begin
            asking = '0;
            for (int i = 0; i < N_PORTS; i++) begin
                asking[i] = req[i * MAX_PORTS + o];
            end
            pick = rotate_pick(asking, out_grant_pos[o]);
            if (pick < N_PORTS) begin
                granted_to[pick][o] = 1'b1;
                out_grant_pos[o]    = step_past(pick);
            end
        end
        for (int i = 0; i < N_PORTS; i++) begin
            pick = rotate_pick(granted_to[i], in_accept_pos[i]);
            if (pick < N_PORTS) begin
                in_accept_pos[i] = step_past(pick);
                result[i]        = t_idx'(pick);
            end
        end
        return result;
    endfunction

    function automatic logic [REQ_W-1:0] rand_request();
        logic [REQ_W-1:0] req;
        logic [7:0]       hot_cols;
        int               shape;
        req   = '0;
        shape = $urandom_range(4);
        case (shape)
            0: begin
                req = {$urandom, $urandom};
            end
            1: begin
                for (int b = 0; b < REQ_W; b++) begin
                    req[b] = ($urandom_range(15) == 0);
                end
            end
            2: begin
                for (int b = 0; b < REQ_W; b++) begin
                    req[b] = ($urandom_range(15) != 0);
                end
            end
            3: begin
                for (int i = 0; i < MAX_PORTS; i++) begin
                    if ($urandom_range(3) != 0) begin
                        req[i * MAX_PORTS + $urandom_range(MAX_PORTS - 1)] = 1'b1;
                    end
                end
            end
            default: begin
                hot_cols = 8'($urandom_range(255));
                for (int i = 0; i < MAX_PORTS; i++) begin
                    if ($urandom_range(1) != 0) begin
                        req[i * MAX_PORTS +: MAX_PORTS] = hot_cols;
                    end
                end
            end
        endcase
        return req;
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER_HEAVY: begin
                send_idle_pct = 37;
                recv_idle_pct = 54;
            end
            IDLE_RECEIVER_HEAVY: begin
                send_idle_pct = 54;
                recv_idle_pct = 37;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Hold until every queued item is accepted and every match has come back.
    task automatic wait_drained();
        while (request_backlog.size() != 0 || req_ch.valid || pending_matches.size() != 0) begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid          <= 1'b0;
            req_ch.request_matrix <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                pending_matches.insert(pending_matches.size(),
                                       schedule_slot(req_ch.request_matrix));
                items_sent++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.valid          <= 1'b1;
                    req_ch.request_matrix <= request_backlog.pop_front();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_match_set seen;
        t_match_set want;
        if (!rst_n) begin
            match_ch.ready <= 1'b0;
        end else begin
            if (match_ch.valid && match_ch.ready) begin
                seen = {match_ch.match_in7, match_ch.match_in6, match_ch.match_in5,
                        match_ch.match_in4, match_ch.match_in3, match_ch.match_in2,
                        match_ch.match_in1, match_ch.match_in0};
                if (pending_matches.size() == 0) begin
                    $error("match result with no request outstanding: %h", seen);
                    err_count++;
                end else begin
                    want = pending_matches.pop_front();
                    results_checked++;
                    for (int i = 0; i < MAX_PORTS; i++) begin
                        if (want[i] != UNMATCHED) begin
                            pairs_matched++;
                        end
                        if (seen[i] !== want[i]) begin
                            $error("match_in%0d: expected %0d, actual %0d", i, want[i], seen[i]);
                            err_count++;
                        end
                    end
                end
            end
            match_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #(12 * 400_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [REQ_W-1:0] directed [$];
        for (int k = 0; k < MAX_PORTS; k++) begin
            out_grant_pos[k] = '0;
            in_accept_pos[k] = '0;
        end
        err_count             = 0;
        items_sent            = 0;
        results_checked       = 0;
        pairs_matched         = 0;
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.request_matrix = '0;
        match_ch.ready        = 1'b0;
        set_idling(IDLE_SENDER_HEAVY);

        directed = {
            64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
            64'h8040_2010_0804_0201, 64'h0102_0408_1020_4080,
            64'hFF00_0000_0000_0000, 64'h8080_8080_8080_8080,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
        };
        // Rotate every grant pointer through all positions under full load.
        for (int k = 0; k < MAX_PORTS; k++) begin
            directed.insert(directed.size(), '1);
        end
        directed.insert(directed.size(), 64'h0F0F_0F0F_0F0F_0F0F);
        directed.insert(directed.size(), 64'hF0F0_F0F0_F0F0_F0F0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[k]) begin
            request_backlog.insert(request_backlog.size(), directed[k]);
        end
        for (int k = 0; k < 430; k++) begin
            request_backlog.insert(request_backlog.size(), rand_request());
        end
        wait_drained();

        set_idling(IDLE_RECEIVER_HEAVY);
        for (int k = 0; k < 430; k++) begin
            request_backlog.insert(request_backlog.size(), rand_request());
        end
        wait_drained();

        set_idling(IDLE_NONE);
        for (int k = 0; k < 440; k++) begin
            request_backlog.insert(request_backlog.size(), rand_request());
        end
        wait_drained();

        repeat (6) @(posedge clk);
        if (pending_matches.size() != 0) begin
            $error("%0d match results never arrived", pending_matches.size());
            err_count++;
        end
        $display("Sent %0d request matrices (directed, random density, hot-spot, one-per-input)",
                 items_sent);
        $display("Checked %0d match results holding %0d matched pairs, under three idling mixes",
                 results_checked, pairs_matched);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== round_robin_crossbar_matcher.f =====
rtl/core/rrcm_pkg.sv
rtl/core/rrcm_req_if.sv
rtl/core/rrcm_match_if.sv
rtl/core/round_robin_crossbar_matcher.sv
verif/round_robin_crossbar_matcher_test.sv
